### rtl/core/lfbf_pkg.sv
package lfbf_pkg;

   localparam int PIXEL_COUNT = 4096;
   localparam int ADDR_W      = $clog2(PIXEL_COUNT);
   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int AXIS_W      = 8;
   localparam int REG_W       = 24;
   localparam int IDX_W       = 24;   // x + y*sx + z*sx*sy with 8-bit axes
   localparam int PIXEL_IDX_W = 16;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   localparam logic [1:0] OP_FILL  = 2'd0;
   localparam logic [1:0] OP_FADE  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_WRITE = 2'd3;

   localparam logic [1:0] CSR_BOX_START = 2'd0;
   localparam logic [1:0] CSR_BOX_END   = 2'd1;
   localparam logic [1:0] CSR_GRID_SIZE = 2'd2;

   localparam logic [REG_W-1:0] GRID_SIZE_RESET = 24'h010001;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
   } walk_step_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] data;
   } ram_wr_type;

   // Upper bound of one axis: lesser of end corner and size minus one (size 0 wraps).
   function automatic logic [AXIS_W-1:0] axis_limit(input logic [AXIS_W-1:0] end_c,
                                                    input logic [AXIS_W-1:0] size);
      logic [AXIS_W-1:0] lim;
      lim = size - AXIS_W'(1);
      return (end_c < lim) ? end_c : lim;
   endfunction

   function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] c,
                                                       input logic [CHAN_W-1:0] s);
      logic [2*CHAN_W-1:0] prod;
      prod = (2*CHAN_W)'(c) * ((2*CHAN_W)'(s) + (2*CHAN_W)'(1));
      return prod[2*CHAN_W-1:CHAN_W];
   endfunction

   function automatic logic [COLOR_W-1:0] fade_pixel(input logic [COLOR_W-1:0] px,
                                                     input logic [CHAN_W-1:0]  s);
      return {scale_channel(px[23:16], s), scale_channel(px[15:8], s),
              scale_channel(px[7:0], s)};
   endfunction

endpackage

### rtl/core/led_frame_box_fill_fade.sv
// Channel   Direction  Handshake             Payload
// req       in         req_tvalid/tready     tuser: opcode; tdata: color, fade, index
// rsp       out        rsp_tvalid/tready     tdata: read_color; tuser: index_valid
// csr       in         csr_we                csr_index, csr_wdata
//
// Fill and fade walk every point of the box (points past the store are walked but
// not written); an empty box walks none. The pixel RAM does one read-modify-write
// per cycle. After reset a clearing pass writes black to all 4096 pixels, one per
// cycle; req_tready stays low meanwhile. A result waiting on rsp does not block the
// next request; the result of that request holds the block until rsp is free.
module led_frame_box_fill_fade (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [47:0]                      req_tdata,   // pixel_color, fade_amount, pixel_index
   input  logic [1:0]                       req_tuser,   // opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [23:0]                      rsp_tdata,   // read_color
   output logic                             rsp_tuser,   // index_valid
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [lfbf_pkg::REG_W-1:0]       csr_wdata
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   localparam int AW = lfbf_pkg::ADDR_W;
   localparam int CW = lfbf_pkg::COLOR_W;

   logic [2:0]                         state_ff, state_in;
   logic [AW-1:0]                      clr_cnt_ff, clr_cnt_in;
   logic [lfbf_pkg::REG_W-1:0]         box_start_ff, box_start_in;
   logic [lfbf_pkg::REG_W-1:0]         box_end_ff, box_end_in;
   logic [lfbf_pkg::REG_W-1:0]         grid_size_ff, grid_size_in;
   logic [1:0]                         cmd_op_ff, cmd_op_in;
   logic [CW-1:0]                      cmd_color_ff, cmd_color_in;
   logic [lfbf_pkg::CHAN_W-1:0]        cmd_fade_ff, cmd_fade_in;
   logic [lfbf_pkg::PIXEL_IDX_W-1:0]   cmd_index_ff, cmd_index_in;
   logic                               cmd_valid_ff, cmd_valid_in;
   logic [CW-1:0]                      res_color_ff, res_color_in;
   logic                               rsp_tvalid_ff, rsp_tvalid_in;
   logic [CW-1:0]                      rsp_color_ff, rsp_color_in;
   logic                               rsp_flag_ff, rsp_flag_in;

   logic                               walk_start;
   logic                               walk_done;
   lfbf_pkg::walk_step_type            step;
   lfbf_pkg::ram_wr_type               upd_wr;
   lfbf_pkg::ram_wr_type               ram_wr;
   logic [AW-1:0]                      rd_addr;
   logic [CW-1:0]                      rd_data;
   logic [lfbf_pkg::CHAN_W-1:0]        scale;

   assign scale = lfbf_pkg::CHAN_MAX - cmd_fade_ff;

   lfbf_box_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (walk_start),
      .box_start (box_start_ff),
      .box_end   (box_end_ff),
      .grid_size (grid_size_ff),
      .step      (step),
      .done      (walk_done)
   );

   lfbf_pixel_update u_update (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .fade_mode (cmd_op_ff == lfbf_pkg::OP_FADE),
      .color     (cmd_color_ff),
      .scale     (scale),
      .rd_data   (rd_data),
      .wr        (upd_wr)
   );

   lfbf_pixel_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      box_start_in  = box_start_ff;
      box_end_in    = box_end_ff;
      grid_size_in  = grid_size_ff;
      cmd_op_in     = cmd_op_ff;
      cmd_color_in  = cmd_color_ff;
      cmd_fade_in   = cmd_fade_ff;
      cmd_index_in  = cmd_index_ff;
      cmd_valid_in  = cmd_valid_ff;
      res_color_in  = res_color_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_flag_in   = rsp_flag_ff;
      walk_start    = 1'b0;
      req_tready    = (state_ff == ST_IDLE);
      ram_wr        = upd_wr;
      rd_addr       = (state_ff == ST_WALK) ? step.addr : cmd_index_ff[AW-1:0];

      if (csr_we) begin
         case (csr_index)
            lfbf_pkg::CSR_BOX_START: box_start_in = csr_wdata;
            lfbf_pkg::CSR_BOX_END:   box_end_in   = csr_wdata;
            lfbf_pkg::CSR_GRID_SIZE: grid_size_in = csr_wdata;
            default: ;
         endcase
      end

      // drop the result once taken
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = clr_cnt_ff;
            ram_wr.data = '0;
            clr_cnt_in  = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(lfbf_pkg::PIXEL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_op_in    = req_tuser;
               cmd_color_in = req_tdata[23:0];
               cmd_fade_in  = req_tdata[31:24];
               cmd_index_in = req_tdata[47:32];
               cmd_valid_in = req_tdata[47:32] <
                              lfbf_pkg::PIXEL_IDX_W'(lfbf_pkg::PIXEL_COUNT);
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_color_in = '0;
            case (cmd_op_ff)
               lfbf_pkg::OP_FILL, lfbf_pkg::OP_FADE: begin
                  walk_start = 1'b1;
                  state_in   = ST_WALK;
               end
               lfbf_pkg::OP_READ: begin
                  state_in = ST_READ;
               end
               default: begin
                  if (cmd_valid_ff) begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = cmd_index_ff[AW-1:0];
                     ram_wr.data = cmd_color_ff;
                  end
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last update write lands this cycle
            state_in = ST_DONE;
         end
         ST_READ: begin
            res_color_in = cmd_valid_ff ? rd_data : '0;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_color_in  = res_color_ff;
               rsp_flag_in   = cmd_valid_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         box_start_ff  <= '0;
         box_end_ff    <= '0;
         grid_size_ff  <= lfbf_pkg::GRID_SIZE_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         box_start_ff  <= box_start_in;
         box_end_ff    <= box_end_in;
         grid_size_ff  <= grid_size_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_op_ff    <= cmd_op_in;
      cmd_color_ff <= cmd_color_in;
      cmd_fade_ff  <= cmd_fade_in;
      cmd_index_ff <= cmd_index_in;
      cmd_valid_ff <= cmd_valid_in;
      res_color_ff <= res_color_in;
      rsp_color_ff <= rsp_color_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_color_ff;
   assign rsp_tuser  = rsp_flag_ff;

endmodule

### rtl/core/lfbf_pixel_ram.sv
module lfbf_pixel_ram (
   input  logic                              clock,
   input  lfbf_pkg::ram_wr_type              wr,
   input  logic [lfbf_pkg::ADDR_W-1:0]       rd_addr,
   output logic [lfbf_pkg::COLOR_W-1:0]      rd_data
);

   logic [lfbf_pkg::COLOR_W-1:0] pixel_mem [lfbf_pkg::PIXEL_COUNT];
   logic [lfbf_pkg::COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         pixel_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= pixel_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/lfbf_box_walk.sv
module lfbf_box_walk (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lfbf_pkg::REG_W-1:0]      box_start,
   input  logic [lfbf_pkg::REG_W-1:0]      box_end,
   input  logic [lfbf_pkg::REG_W-1:0]      grid_size,
   output lfbf_pkg::walk_step_type         step,
   output logic                            done
);

   localparam logic [2:0] W_IDLE = 3'd0;
   localparam logic [2:0] W_MUL1 = 3'd1;
   localparam logic [2:0] W_MUL2 = 3'd2;
   localparam logic [2:0] W_INIT = 3'd3;
   localparam logic [2:0] W_RUN  = 3'd4;

   localparam int AW = lfbf_pkg::AXIS_W;
   localparam int IW = lfbf_pkg::IDX_W;

   logic [2:0]      state_ff, state_in;
   logic [AW-1:0]   x0_ff, x0_in, y0_ff, y0_in, z0_ff, z0_in;
   logic [AW-1:0]   x1_ff, x1_in, y1_ff, y1_in, z1_ff, z1_in;
   logic [AW-1:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic            empty_ff, empty_in;
   logic [2*AW-1:0] sxy_ff, sxy_in, ysx_ff, ysx_in;
   logic [IW-1:0]   zoff_ff, zoff_in;
   logic [AW-1:0]   x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [IW-1:0]   xbase_ff, xbase_in, row_ff, row_in, idx_ff, idx_in;

   always_comb begin
      logic [AW-1:0] lx, ly, lz;
      logic [IW-1:0] base;
      logic [IW-1:0] next_row;
      logic [IW-1:0] next_xbase;

      lx = lfbf_pkg::axis_limit(box_end[7:0], grid_size[7:0]);
      ly = lfbf_pkg::axis_limit(box_end[15:8], grid_size[15:8]);
      lz = lfbf_pkg::axis_limit(box_end[23:16], grid_size[23:16]);
      base       = IW'(x0_ff) + IW'(ysx_ff);
      next_row   = row_ff + IW'(sx_ff);
      next_xbase = xbase_ff + IW'(1);

      state_in = state_ff;
      x0_in = x0_ff; y0_in = y0_ff; z0_in = z0_ff;
      x1_in = x1_ff; y1_in = y1_ff; z1_in = z1_ff;
      sx_in = sx_ff; sy_in = sy_ff;
      empty_in = empty_ff;
      sxy_in = sxy_ff; ysx_in = ysx_ff; zoff_in = zoff_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      xbase_in = xbase_ff; row_in = row_ff; idx_in = idx_ff;
      done = 1'b0;

      case (state_ff)
         W_IDLE: begin
            if (start) begin
               x0_in = box_start[7:0];
               y0_in = box_start[15:8];
               z0_in = box_start[23:16];
               x1_in = lx;
               y1_in = ly;
               z1_in = lz;
               sx_in = grid_size[7:0];
               sy_in = grid_size[15:8];
               empty_in = (box_start[7:0] > lx) || (box_start[15:8] > ly) ||
                          (box_start[23:16] > lz);
               state_in = W_MUL1;
            end
         end
         W_MUL1: begin
            sxy_in = (2*AW)'(sx_ff) * (2*AW)'(sy_ff);
            ysx_in = (2*AW)'(y0_ff) * (2*AW)'(sx_ff);
            state_in = W_MUL2;
         end
         W_MUL2: begin
            zoff_in = IW'(z0_ff) * IW'(sxy_ff);
            if (empty_ff) begin
               done = 1'b1;
               state_in = W_IDLE;
            end else begin
               state_in = W_INIT;
            end
         end
         W_INIT: begin
            xbase_in = base;
            row_in   = base;
            idx_in   = base + zoff_ff;
            x_in = x0_ff;
            y_in = y0_ff;
            z_in = z0_ff;
            state_in = W_RUN;
         end
         W_RUN: begin
            // z innermost, then y, then x
            if (z_ff != z1_ff) begin
               z_in   = z_ff + AW'(1);
               idx_in = idx_ff + IW'(sxy_ff);
            end else if (y_ff != y1_ff) begin
               y_in   = y_ff + AW'(1);
               z_in   = z0_ff;
               row_in = next_row;
               idx_in = next_row + zoff_ff;
            end else if (x_ff != x1_ff) begin
               x_in     = x_ff + AW'(1);
               y_in     = y0_ff;
               z_in     = z0_ff;
               xbase_in = next_xbase;
               row_in   = next_xbase;
               idx_in   = next_xbase + zoff_ff;
            end else begin
               done     = 1'b1;
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase

      step.valid = (state_ff == W_RUN) && (idx_ff < IW'(lfbf_pkg::PIXEL_COUNT));
      step.addr  = idx_ff[lfbf_pkg::ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x0_ff <= x0_in; y0_ff <= y0_in; z0_ff <= z0_in;
      x1_ff <= x1_in; y1_ff <= y1_in; z1_ff <= z1_in;
      sx_ff <= sx_in; sy_ff <= sy_in;
      empty_ff <= empty_in;
      sxy_ff <= sxy_in; ysx_ff <= ysx_in; zoff_ff <= zoff_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      xbase_ff <= xbase_in; row_ff <= row_in; idx_ff <= idx_in;
   end

endmodule

### rtl/core/lfbf_pixel_update.sv
module lfbf_pixel_update (
   input  logic                            clock,
   input  logic                            reset,
   input  lfbf_pkg::walk_step_type         step,
   input  logic                            fade_mode,
   input  logic [lfbf_pkg::COLOR_W-1:0]    color,
   input  logic [lfbf_pkg::CHAN_W-1:0]     scale,
   input  logic [lfbf_pkg::COLOR_W-1:0]    rd_data,
   output lfbf_pkg::ram_wr_type            wr
);

   logic                          s2_valid_ff, s2_valid_in;
   logic [lfbf_pkg::ADDR_W-1:0]   s2_addr_ff, s2_addr_in;
   logic                          fwd_ff, fwd_in;
   logic [lfbf_pkg::COLOR_W-1:0]  fwd_data_ff, fwd_data_in;
   logic [lfbf_pkg::COLOR_W-1:0]  cur;

   always_comb begin
      // memory returns stale data when the same pixel was written in the read cycle
      cur = fwd_ff ? fwd_data_ff : rd_data;
      wr.en   = s2_valid_ff;
      wr.addr = s2_addr_ff;
      wr.data = fade_mode ? lfbf_pkg::fade_pixel(cur, scale) : color;

      s2_valid_in = step.valid;
      s2_addr_in  = step.addr;
      fwd_in      = step.valid && s2_valid_ff && (s2_addr_ff == step.addr);
      fwd_data_in = wr.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         fwd_ff      <= fwd_in;
      end
      s2_addr_ff  <= s2_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

endmodule
